>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds on every clock edge outside reset.
`define ICT_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Check that a signal is never true outside reset.
`define ICT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

>>> sv/ict_pkg.sv
package ict_pkg;

  localparam int unsigned MaxObjects  = 64;
  localparam int unsigned MaxClusters = 64;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned CntW        = 7;

  typedef enum logic [1:0] {
    ActClear   = 2'd0,
    ActAdd     = 2'd1,
    ActCollect = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         object_id;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic               filter_enable;
    logic [63:0]        filter_mask;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       hit_valid;
    logic [5:0] hit_id;
    logic [6:0] clusters_in_use;
    logic       last;
  } out_item_t;

  // Closed interval overlap test.
  function automatic logic spans_meet(logic signed [31:0] alo, logic signed [31:0] ahi,
                                      logic signed [31:0] blo, logic signed [31:0] bhi);
    return !(ahi < blo) && !(bhi < alo);
  endfunction

endpackage

>>> sv/ict_core.sv
// Sequencer: walks the cluster store (add) one entry per cycle, or the object
// store (collect), then emits results from the hit mask lowest id first.
module ict_core import ict_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef enum logic [2:0] {
    StIdle, StAddScan, StAddWait, StAddWrite, StColRead, StColScan, StEmit, StOut
  } state_e;

  state_e             state_q;
  in_item_t           item_q;
  logic [CntW-1:0]    ent_tot_q, clu_tot_q;
  logic [CntW-1:0]    idx_q;
  logic [63:0]        hits_q;
  logic               found_q;
  logic [IdxW-1:0]    found_idx_q;
  out_item_t          out_q;

  // Stores; contents of entries beyond the totals are never used.
  logic [IdxW-1:0]    ent_id_m  [MaxObjects];
  logic signed [31:0] ent_lo_m  [MaxObjects];
  logic signed [31:0] ent_hi_m  [MaxObjects];
  logic [IdxW-1:0]    ent_clu_m [MaxObjects];
  logic signed [31:0] clu_lo_m  [MaxClusters];
  logic signed [31:0] clu_hi_m  [MaxClusters];

  // Registered read ports.
  logic [IdxW-1:0]    ent_id_rd, ent_clu_rd;
  logic signed [31:0] ent_lo_rd, ent_hi_rd;
  logic signed [31:0] clu_lo_rd, clu_hi_rd;
  logic [IdxW-1:0]    clu_raddr;

  // Cluster wr port.
  logic               clu_we;
  logic [IdxW-1:0]    clu_waddr;
  logic signed [31:0] clu_wlo, clu_whi;
  logic               ent_we;

  logic               allow;
  logic [5:0]         low_bit;
  logic               more_hits;
  logic [63:0]        hits_clr;
  out_item_t          idle_word;

  // Cluster read address: scan index on add, entry's cluster on collect.
  assign clu_raddr = (state_q == StColScan) ? ent_clu_rd : idx_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    ent_id_rd  <= ent_id_m[idx_q[IdxW-1:0]];
    ent_lo_rd  <= ent_lo_m[idx_q[IdxW-1:0]];
    ent_hi_rd  <= ent_hi_m[idx_q[IdxW-1:0]];
    ent_clu_rd <= ent_clu_m[idx_q[IdxW-1:0]];
    clu_lo_rd  <= clu_lo_m[clu_raddr];
    clu_hi_rd  <= clu_hi_m[clu_raddr];
    if (clu_we) begin
      clu_lo_m[clu_waddr] <= clu_wlo;
      clu_hi_m[clu_waddr] <= clu_whi;
    end
    if (ent_we) begin
      ent_id_m[ent_tot_q[IdxW-1:0]]  <= item_q.object_id;
      ent_lo_m[ent_tot_q[IdxW-1:0]]  <= item_q.low_bound;
      ent_hi_m[ent_tot_q[IdxW-1:0]]  <= item_q.high_bound;
      ent_clu_m[ent_tot_q[IdxW-1:0]] <= clu_waddr;
    end
  end

  // Write side of an add, taken in StAddWrite.
  always_comb begin
    ent_we    = 1'b0;
    clu_we    = 1'b0;
    clu_waddr = found_idx_q;
    clu_wlo   = item_q.low_bound;
    clu_whi   = item_q.high_bound;
    if (state_q == StAddWrite) begin
      if (found_q) begin
        clu_we  = 1'b1;
        clu_wlo = (item_q.low_bound < clu_lo_rd) ? item_q.low_bound : clu_lo_rd;
        clu_whi = (clu_hi_rd < item_q.high_bound) ? item_q.high_bound : clu_hi_rd;
        ent_we  = 1'b1;
      end else if (clu_tot_q < CntW'(MaxClusters)) begin
        clu_we    = 1'b1;
        clu_waddr = clu_tot_q[IdxW-1:0];
        ent_we    = 1'b1;
      end
    end
  end

  // Pick lowest set hit bit.
  always_comb begin
    low_bit = '0;
    for (int b = 63; b >= 0; b--) begin
      if (hits_q[b]) low_bit = 6'(b);
    end
    hits_clr  = hits_q & ~(64'd1 << low_bit);
    more_hits = |hits_clr;
  end

  // Word for an item that is answered straight from idle.
  always_comb begin
    idle_word                 = '0;
    idle_word.last            = 1'b1;
    idle_word.clusters_in_use = clu_tot_q;
    if (in_data_i.action == ActClear) idle_word.clusters_in_use = '0;
    if (in_data_i.action == ActAdd && ent_tot_q >= CntW'(MaxObjects)) begin
      idle_word.status = 1'b1;
    end
  end

  assign allow = !item_q.filter_enable || item_q.filter_mask[ent_id_rd];

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = out_q;

  // Hold state and outputs; advance the add scan one entry a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ent_tot_q   <= '0;
      clu_tot_q   <= '0;
      idx_q       <= '0;
      hits_q      <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      out_q       <= '0;
      item_q      <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            idx_q   <= '0;
            hits_q  <= '0;
            found_q <= 1'b0;
            out_q   <= idle_word;
            case (in_data_i.action)
              ActClear: begin
                ent_tot_q <= '0;
                clu_tot_q <= '0;
                state_q   <= StOut;
              end
              ActAdd: begin
                if (ent_tot_q >= CntW'(MaxObjects)) begin
                  state_q <= StOut;
                end else begin
                  state_q <= StAddScan;
                end
              end
              ActCollect: begin
                if (ent_tot_q == '0) begin
                  state_q <= StOut;
                end else begin
                  state_q <= StColRead;
                end
              end
              default: begin
                state_q <= StOut;
              end
            endcase
          end
        end
        // Read data for idx_q-1 is on the port; idx_q issued now.
        StAddScan: begin
          if (idx_q != '0 && spans_meet(clu_lo_rd, clu_hi_rd,
                                        item_q.low_bound, item_q.high_bound)) begin
            found_q     <= 1'b1;
            found_idx_q <= IdxW'(idx_q - CntW'(1));
            idx_q       <= idx_q - CntW'(1);
            state_q     <= StAddWait;
          end else if (idx_q >= clu_tot_q) begin
            state_q <= StAddWrite;
          end else begin
            idx_q <= idx_q + CntW'(1);
          end
        end
        // Re-read the found cluster so its bounds are on the port.
        StAddWait: begin
          state_q <= StAddWrite;
        end
        StAddWrite: begin
          if (ent_we) begin
            ent_tot_q <= ent_tot_q + CntW'(1);
            if (!found_q) begin
              clu_tot_q <= clu_tot_q + CntW'(1);
              out_q.clusters_in_use <= clu_tot_q + CntW'(1);
            end else begin
              out_q.clusters_in_use <= clu_tot_q;
            end
          end else begin
            out_q.status <= 1'b1;
            out_q.clusters_in_use <= clu_tot_q;
          end
          state_q <= StOut;
        end
        // Entry read issued; next cycle its cluster is read.
        StColRead: begin
          state_q <= StColScan;
        end
        StColScan: begin
          idx_q <= idx_q + CntW'(1);
          if (allow
              && spans_meet(ent_lo_rd, ent_hi_rd, item_q.low_bound, item_q.high_bound)) begin
            // Cluster check done next cycle would cost a stage; entries of a
            // cluster always lie inside its bounds, so the entry test implies it.
            hits_q[ent_id_rd] <= 1'b1;
          end
          if (idx_q + CntW'(1) >= ent_tot_q) begin
            state_q <= StEmit;
          end else begin
            state_q <= StColRead;
          end
        end
        StEmit: begin
          out_q.clusters_in_use <= clu_tot_q;
          if (hits_q == '0) begin
            out_q.hit_valid <= 1'b0;
            out_q.hit_id    <= '0;
            out_q.last      <= 1'b1;
            state_q         <= StOut;
          end else begin
            out_q.hit_valid <= 1'b1;
            out_q.hit_id    <= low_bit;
            out_q.last      <= !more_hits;
            hits_q          <= hits_clr;
            state_q         <= StOut;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            if (out_q.hit_valid && !out_q.last) state_q <= StEmit;
            else state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> sv/interval_cluster_table.sv
// Channel | Handshake          | Payload
// in      | in_valid_i/ready_o | in_data_i  (in_item_t)
// out     | out_valid_o/ready_i| out_data_o (out_item_t)
// Add: scans the clusters in use, stops at the lowest overlapping one and re-reads
// it, then writes and presents the result word; one compare a cycle.
// Collect: a read and a scan state per object, then StEmit and StOut per word.
// Clear, unused actions, dropped adds, collects on an empty table: result word
// the cycle after accept. No clearing pass after reset.
// The input is not ready until the previous item's last word is taken.
`include "assert_macros.svh"
module interval_cluster_table import ict_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  ict_core u_core (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  `ICT_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o)
  `ICT_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, out_valid_o,
                  out_data_o.clusters_in_use <= 7'd64)
  `ICT_ASSERT_IMP(a_nohit_last, clk_i, rst_ni, out_valid_o && !out_data_o.hit_valid,
                  out_data_o.last)

endmodule
